### rtl/core/hrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrf_pkg
// Shared types, codes and constants of the HTTP request framer.
// ----------------------------------------------------------------------------
package hrf_pkg;

  localparam int unsigned MAX_BACKENDS = 8;
  localparam logic [3:0]  NAME_LEN     = 4'd14;
  localparam logic [16:0] SAT17        = 17'h1FFFF;

  // opcodes of the input word
  localparam logic [1:0] OP_OPEN  = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_FORWARD   = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_CLOSED    = 2'd2;

  // configuration register indexes
  localparam logic REG_UPSTREAM_COUNT = 1'b0;
  localparam logic REG_MAX_BYTES      = 1'b1;

  typedef enum logic [2:0] {
    LP_NAME,
    LP_COLON,
    LP_BLANK,
    LP_DIGITS,
    LP_DONE
  } len_phase_t;

  typedef struct packed {
    len_phase_t  phase;
    logic [3:0]  name_match;
    logic [16:0] value;
    logic [16:0] name_end;
  } parse_st_t;

  // lower-case "content-length"
  function automatic logic [7:0] name_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "c";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "l";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/core/http_request_framer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Results are registered: a result is in the output register in the cycle after its word is accepted.
// Throughput: one word per cycle while no result is stalled; the per-word state update is a single combinational pass.
// The output register stalls input only while a result waits and out_ready is low.
// Reset (synchronous, rst_n low): connection idle, round robin at backend 0,
// upstream_count 2, max_request_bytes 32768, no result pending.
// ----------------------------------------------------------------------------
// http_request_framer_core
// Frames one HTTP request per connection and picks a backend round robin.
// ----------------------------------------------------------------------------
module http_request_framer_core
  import hrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_total_length,
  output logic [2:0]  out_upstream_index,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_ACTIVE
  } frame_t;

  frame_t      frame_r,      frame_nxt;
  parse_st_t   parse_r,      parse_nxt;
  parse_st_t   parse_step;
  logic [1:0]  blank_r,      blank_nxt;
  logic [16:0] byte_count_r, byte_count_nxt;
  logic [16:0] expected_r,   expected_nxt;
  logic [2:0]  rr_r,         rr_nxt;
  logic [2:0]  chosen_r,     chosen_nxt;
  logic [3:0]  upc_r;
  logic [15:0] max_r;
  logic        out_valid_r,  out_valid_nxt;
  logic [1:0]  status_r,     status_nxt;
  logic [15:0] total_r,      total_nxt;
  logic [2:0]  index_r,      index_nxt;

  logic        accept;
  logic        cfg_write;
  logic [3:0]  n_backends;
  logic [3:0]  pick;
  logic [3:0]  pick_inc;
  logic [16:0] body;
  logic [17:0] total_sum;
  logic [16:0] total_sat;
  logic        done;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_pready = 1'b1;
  assign cfg_write = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_BYTES) ? {16'b0, max_r} : {28'b0, upc_r};

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_total_length   = total_r;
  assign out_upstream_index = index_r;

  hrf_length_parse u_parse (
    .cur       (parse_r),
    .data_byte (in_data_byte),
    .pos       (byte_count_r),
    .nxt       (parse_step)
  );

  // backend count clamped to 1..MAX_BACKENDS
  assign n_backends = (upc_r == 4'd0) ? 4'd1
                    : (upc_r > 4'(MAX_BACKENDS)) ? 4'(MAX_BACKENDS) : upc_r;
  assign pick       = ({1'b0, rr_r} >= n_backends) ? 4'd0 : {1'b0, rr_r};
  assign pick_inc   = pick + 4'd1;

  // header end: total = bytes up to and including this LF + body
  assign body      = ((parse_step.phase == LP_DIGITS || parse_step.phase == LP_DONE) &&
                      ({1'b0, parse_step.name_end} + 18'd6 <= {1'b0, byte_count_r}))
                     ? parse_step.value : 17'd0;
  assign total_sum = {1'b0, byte_count_r} + 18'd1 + {1'b0, body};
  assign total_sat = total_sum[17] ? SAT17 : total_sum[16:0];

  always_comb begin
    frame_nxt      = frame_r;
    parse_nxt      = parse_r;
    blank_nxt      = blank_r;
    byte_count_nxt = byte_count_r;
    expected_nxt   = expected_r;
    rr_nxt         = rr_r;
    chosen_nxt     = chosen_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    status_nxt     = status_r;
    total_nxt      = total_r;
    index_nxt      = index_r;
    done           = 1'b0;
    if (accept) begin
      case (in_opcode)
        OP_OPEN: begin
          chosen_nxt     = pick[2:0];
          rr_nxt         = (pick_inc >= n_backends) ? 3'd0 : pick_inc[2:0];
          frame_nxt      = FR_ACTIVE;
          parse_nxt      = '{phase: LP_NAME, name_match: 4'd0, value: 17'd0,
                             name_end: 17'd0};
          blank_nxt      = 2'd0;
          byte_count_nxt = 17'd0;
          expected_nxt   = 17'd0;
        end
        OP_CLOSE: begin
          if (frame_r == FR_ACTIVE) begin
            frame_nxt     = FR_IDLE;
            out_valid_nxt = 1'b1;
            status_nxt    = ST_CLOSED;
            total_nxt     = 16'd0;
            index_nxt     = chosen_r;
          end
        end
        OP_DATA: begin
          if (frame_r == FR_ACTIVE) begin
            byte_count_nxt = byte_count_r + 17'd1;
            if (expected_r == 17'd0) begin
              parse_nxt = parse_step;
              if (in_data_byte == 8'h0D) begin
                blank_nxt = (blank_r == 2'd2) ? 2'd3 : 2'd1;
              end else if (in_data_byte == 8'h0A && blank_r == 2'd1) begin
                blank_nxt = 2'd2;
              end else if (in_data_byte == 8'h0A && blank_r == 2'd3) begin
                blank_nxt    = 2'd0;
                expected_nxt = total_sat;
                if (total_sat > {1'b0, max_r}) begin
                  done       = 1'b1;
                  status_nxt = ST_TOO_LARGE;
                end
              end else begin
                blank_nxt = 2'd0;
              end
            end
            if (!done) begin
              if (expected_nxt != 17'd0 && byte_count_nxt >= expected_nxt) begin
                done       = 1'b1;
                status_nxt = ST_FORWARD;
              end else if (byte_count_nxt >= {1'b0, max_r}) begin
                done       = 1'b1;
                status_nxt = ST_TOO_LARGE;
              end
            end
            if (done) begin
              frame_nxt     = FR_IDLE;
              out_valid_nxt = 1'b1;
              total_nxt     = expected_nxt[16] ? 16'hFFFF : expected_nxt[15:0];
              index_nxt     = chosen_r;
            end
          end
        end
        default: begin
          // unused opcode: drop the word
          frame_nxt = frame_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r      <= FR_IDLE;
      parse_r      <= '{phase: LP_NAME, name_match: 4'd0, value: 17'd0, name_end: 17'd0};
      blank_r      <= 2'd0;
      byte_count_r <= 17'd0;
      expected_r   <= 17'd0;
      rr_r         <= 3'd0;
      chosen_r     <= 3'd0;
      upc_r        <= 4'd2;
      max_r        <= 16'd32768;
      out_valid_r  <= 1'b0;
    end else begin
      frame_r      <= frame_nxt;
      parse_r      <= parse_nxt;
      blank_r      <= blank_nxt;
      byte_count_r <= byte_count_nxt;
      expected_r   <= expected_nxt;
      rr_r         <= rr_nxt;
      chosen_r     <= chosen_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_write) begin
        if (cfg_paddr[2] == REG_UPSTREAM_COUNT) upc_r <= cfg_pwdata[3:0];
        else                                    max_r <= cfg_pwdata[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    total_r  <= total_nxt;
    index_r  <= index_nxt;
  end

endmodule
`default_nettype wire

### rtl/core/hrf_length_parse.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrf_length_parse
// Content-length scanner: name match, colon, blanks and decimal digits.
// ----------------------------------------------------------------------------
module hrf_length_parse
  import hrf_pkg::*;
(
  input  parse_st_t   cur,
  input  logic [7:0]  data_byte,
  input  logic [16:0] pos,
  output parse_st_t   nxt
);

  logic [7:0]  folded;
  logic [3:0]  match_inc;
  logic        is_digit;
  logic        is_blank;
  logic [20:0] accum;

  assign folded    = (data_byte >= "A" && data_byte <= "Z") ? data_byte + 8'd32 : data_byte;
  assign is_digit  = (data_byte >= "0") && (data_byte <= "9");
  assign is_blank  = (data_byte == " ") || (data_byte == 8'h09);
  // value * 10 + digit as two shifts and two adds
  assign accum     = ({4'b0, cur.value} << 3) + ({4'b0, cur.value} << 1)
                     + {17'b0, data_byte[3:0]};
  assign match_inc = (folded == name_char(cur.name_match)) ? cur.name_match + 4'd1
                   : (folded == "c") ? 4'd1 : 4'd0;

  always_comb begin
    nxt = cur;
    case (cur.phase)
      LP_NAME: begin
        if (match_inc >= NAME_LEN) begin
          nxt.name_match = 4'd0;
          nxt.name_end   = pos;
          nxt.phase      = LP_COLON;
        end else begin
          nxt.name_match = match_inc;
        end
      end
      LP_COLON: begin
        if (data_byte == ":") nxt.phase = LP_BLANK;
      end
      LP_BLANK, LP_DIGITS: begin
        if (cur.phase == LP_BLANK && is_blank) begin
          nxt.phase = LP_BLANK;
        end else if (is_digit) begin
          nxt.phase = LP_DIGITS;
          nxt.value = (accum > {4'b0, SAT17}) ? SAT17 : accum[16:0];
        end else begin
          nxt.phase = LP_DONE;
        end
      end
      LP_DONE: nxt = cur;
      default: nxt = cur;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/hrf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrf_checker
// Port-level checks of the HTTP request framer, bound to the top level.
// ----------------------------------------------------------------------------
module hrf_checker
  import hrf_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [15:0] out_total_length,
  input wire logic [2:0]  out_upstream_index
);

  // a stalled result holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_total_length) && $stable(out_upstream_index))
    else $error("result word changed while stalled");

  // input stalls while a result waits and out_ready is low
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  // a new result follows an accepted word
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without an accepted word");

  // closed early carries no length
  a_closed_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_CLOSED |-> out_total_length == 16'd0)
    else $error("closed early with nonzero length");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_FORWARD || out_status == ST_TOO_LARGE ||
    out_status == ST_CLOSED)
    else $error("undefined status code");

endmodule

bind http_request_framer_core hrf_checker u_hrf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_status         (out_status),
  .out_total_length   (out_total_length),
  .out_upstream_index (out_upstream_index)
);
`default_nettype wire
